@@ src/uartrx_pkg.sv @@
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants of the 8N1 receiver with receive FIFO.
// ----------------------------------------------------------------------------
package uartrx_pkg;

  // default receive FIFO depth
  localparam int unsigned FIFO_DEPTH = 16;

  // configuration reset values
  localparam logic [7:0] BIT_PERIOD_RST   = 8'd205;
  localparam logic [7:0] FIRST_SAMPLE_RST = 8'd254;

  // data bits per frame, and the sample count that ends a frame
  localparam logic [3:0] DATA_BITS = 4'd8;

  // configuration register index
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD   = 1'b0,
    CFG_FIRST_SAMPLE = 1'b1
  } cfg_idx_e;

  // input item: one tick
  typedef struct packed {
    logic rx_line;
    logic read_req;
  } uartrx_in_t;

  // result item
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       available;
    logic       byte_dropped;
  } uartrx_out_t;

  // per-tick status from the receive FIFO
  typedef struct packed {
    logic pop_ok;
    logic dropped;
    logic avail;
  } uartrx_fifo_stat_t;

endpackage

@@ src/uart_rx_with_fifo_core.sv @@
// ----------------------------------------------------------------------------
// uart_rx_with_fifo_core
// 8N1 receiver advanced by one timer tick per item, with a receive FIFO.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  rx_line, read_req
//   out      output     out_valid_o/out_stall_i read_valid, read_byte,
//                                              available, byte_dropped
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One tick is accepted every cycle while in_stall_o is low; its result passes
// through the registered FIFO read and then the output register.
// Reset clears all control state; the FIFO storage needs no clearing pass.
// out_stall_i holds the result and the FIFO-read stage; in_stall_o rises
// only when both are occupied and the output cannot move.
// ----------------------------------------------------------------------------
module uart_rx_with_fifo_core #(
  parameter int unsigned FifoDepth = uartrx_pkg::FIFO_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  uartrx_pkg::uartrx_in_t              in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output uartrx_pkg::uartrx_out_t             out_data_o,
  input  logic                                cfg_we_i,
  input  logic [uartrx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [7:0]                          cfg_wdata_i
);
  import uartrx_pkg::*;

  logic [7:0] bit_period_q, first_sample_q;
  logic       line_prev_q;
  logic       receiving_q, receiving_d;
  logic [7:0] tick_q, tick_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       push;

  logic              in_acc;
  logic              s1_valid_q, s1_adv;
  uartrx_fifo_stat_t s1_stat_q, fifo_stat;
  logic [7:0]        fifo_rd;
  logic              out_valid_q;
  uartrx_out_t       out_q;

  // handshake: the read stage moves on when the output is free or taken
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q   <= BIT_PERIOD_RST;
      first_sample_q <= FIRST_SAMPLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BIT_PERIOD:   bit_period_q   <= cfg_wdata_i;
        CFG_FIRST_SAMPLE: first_sample_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // frame timing and bit sampling for one tick
  always_comb begin
    receiving_d = receiving_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    push        = 1'b0;
    if (!receiving_q) begin
      if (line_prev_q && !in_data_i.rx_line) begin
        receiving_d = 1'b1;
        tick_d      = first_sample_q;
        bit_d       = '0;
      end
    end else if (tick_q != '0) begin
      tick_d = tick_q - 8'd1;
    end else begin
      tick_d = bit_period_q;
      if (bit_q < DATA_BITS) begin
        bit_d   = bit_q + 4'd1;
        shift_d = {in_data_i.rx_line, shift_q[7:1]};
      end else begin
        receiving_d = 1'b0;
        push        = 1'b1;
      end
    end
  end

  // receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_prev_q <= 1'b1;
      receiving_q <= 1'b0;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
    end else if (in_acc) begin
      line_prev_q <= in_data_i.rx_line;
      receiving_q <= receiving_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
    end
  end

  // receive FIFO
  uartrx_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_acc),
    .pop_i       (in_acc && in_data_i.read_req),
    .push_i      (in_acc && push),
    .push_data_i (shift_q),
    .stat_o      (fifo_stat),
    .rd_data_o   (fifo_rd)
  );

  // read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage status
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_stat_q <= fifo_stat;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.read_valid   <= s1_stat_q.pop_ok;
      out_q.read_byte    <= s1_stat_q.pop_ok ? fifo_rd : 8'd0;
      out_q.available    <= s1_stat_q.avail;
      out_q.byte_dropped <= s1_stat_q.dropped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // input stalls only with a loaded read stage that cannot move
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked pipeline");

  // a drop never pairs with a pop in the same tick
  a_drop_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_dropped |-> !out_data_o.read_valid)
    else $error("byte dropped on a popping tick");

  // no popped byte means a zero byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |-> out_data_o.read_byte == 8'd0)
    else $error("nonzero byte without a pop");

  // bit counter never runs past the stop sample
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    receiving_q |-> bit_q <= DATA_BITS)
    else $error("bit counter out of range");
`endif

endmodule

@@ src/uartrx_fifo.sv @@
// ----------------------------------------------------------------------------
// uartrx_fifo
// Receive FIFO: pop before push in one tick, registered read data.
// ----------------------------------------------------------------------------
module uartrx_fifo #(
  parameter int unsigned Depth = uartrx_pkg::FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          pop_i,
  input  logic                          push_i,
  input  logic [7:0]                    push_data_i,
  output uartrx_pkg::uartrx_fifo_stat_t stat_o,
  output logic [7:0]                    rd_data_o
);
  import uartrx_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      rd_q;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop_ok, push_ok;

  // pop first, so a full FIFO still takes a push on a popping tick
  assign pop_ok  = pop_i && (count_q != '0);
  assign push_ok = push_i && ((count_q != FullCnt) || pop_ok);

  // pointer and count update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (pop_ok) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);
    end
    if (push_ok) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + PtrW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  assign stat_o.pop_ok  = pop_ok;
  assign stat_o.dropped = push_i && !push_ok;
  assign stat_o.avail   = (count_d != '0);
  assign rd_data_o      = rd_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (en_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // storage: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (en_i) begin
      rd_q <= mem_q[head_q];
    end
  end

`ifndef SYNTH
  // never more entries than the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("fifo count above depth");

  // a drop only happens with a full FIFO and no pop
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.dropped |-> (count_q == FullCnt) && !pop_ok)
    else $error("byte dropped while FIFO had room");

  // pointers agree when the FIFO is empty
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty FIFO with unequal pointers");
`endif

endmodule

@@ tb/tb_uart_rx_with_fifo_core.sv @@
// ----------------------------------------------------------------------------
// tb_uart_rx_with_fifo_core
// Self-checking bench for the tick-driven 8N1 receiver with receive FIFO.
// Ticks carry shaped frames and line noise with random read requests. Each
// accepted tick updates a scoreboard that mirrors the receiver and FIFO, and
// every result leaving the block is compared field by field with the oldest
// predicted tick status. Both handshakes idle at random, the result side
// holds off once for a long stretch, and the timing registers are swept
// across several settings between phases.
// ----------------------------------------------------------------------------
module tb_uart_rx_with_fifo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import uartrx_pkg::*;

  localparam int unsigned IDLE_PCT    = 22;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_WAIT = 8;
  localparam int unsigned STUCK_LIMIT = 2000;

  // mirror of the receiver and FIFO, holding the per-tick status it predicts
  class rx_status_scoreboard;
    logic [7:0]  bit_period;
    logic [7:0]  first_sample;
    logic        line_prev;
    logic        receiving;
    logic [7:0]  tick_count;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  byte_store [FIFO_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    uartrx_out_t status_q [$];
    int unsigned errors;

    function new();
      bit_period   = BIT_PERIOD_RST;
      first_sample = FIRST_SAMPLE_RST;
      line_prev    = 1'b1;
      receiving    = 1'b0;
      tick_count   = '0;
      bit_count    = '0;
      shift_reg    = '0;
      head         = 0;
      tail         = 0;
      fill         = 0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_BIT_PERIOD:   bit_period = value;
        CFG_FIRST_SAMPLE: first_sample = value;
        default: ;
      endcase
    endfunction

    // advance one tick and queue the status it must produce
    function void note_tick(uartrx_in_t item);
      uartrx_out_t st;
      st = '0;
      // pop is served before the push of the same tick
      if (item.read_req && fill > 0) begin
        st.read_valid = 1'b1;
        st.read_byte  = byte_store[head];
        head = (head + 1) % FIFO_DEPTH;
        fill--;
      end
      if (!receiving) begin
        if (line_prev && !item.rx_line) begin
          receiving  = 1'b1;
          tick_count = first_sample;
          bit_count  = '0;
        end
      end else if (tick_count != 0) begin
        tick_count--;
      end else begin
        tick_count = bit_period;
        if (bit_count < DATA_BITS) begin
          bit_count++;
          shift_reg = {item.rx_line, shift_reg[7:1]};
        end else begin
          receiving = 1'b0;
          if (fill < FIFO_DEPTH) begin
            byte_store[tail] = shift_reg;
            tail = (tail + 1) % FIFO_DEPTH;
            fill++;
          end else begin
            st.byte_dropped = 1'b1;
          end
        end
      end
      line_prev    = item.rx_line;
      st.available = (fill > 0);
      status_q.push_back(st);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_status(uartrx_out_t got);
      uartrx_out_t want;
      if (status_q.size() == 0) begin
        $display("%0t result with nothing pending: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("available", 8'(want.available), 8'(got.available));
      compare_field("byte_dropped", 8'(want.byte_dropped), 8'(got.byte_dropped));
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  uartrx_in_t             in_data = '{rx_line: 1'b1, read_req: 1'b0};
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  uartrx_out_t            out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_BIT_PERIOD;
  logic [7:0]             cfg_wdata = '0;

  rx_status_scoreboard    sb = new();
  bit                     calm = 1'b0;
  bit                     hold_go = 1'b0;
  int unsigned            ticks_sent = 0;
  int unsigned            stuck_cycles = 0;

  uart_rx_with_fifo_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_status(out_data);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one tick, with random gaps, and note it once accepted
  task automatic send_tick(input logic line, input logic req);
    uartrx_in_t item;
    item.rx_line  = line;
    item.read_req = req;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_tick(item);
    ticks_sent++;
  endtask

  function automatic logic read_roll(int unsigned read_pct);
    return $urandom_range(99) < read_pct;
  endfunction

  // idle-high ticks until a fresh falling edge can start a frame
  task automatic settle_line(int unsigned read_pct);
    while (sb.receiving || !sb.line_prev) send_tick(1'b1, read_roll(read_pct));
  endtask

  // one well-formed frame at the current timing, start edge to ninth sample
  task automatic send_frame(input logic [7:0] data, input int unsigned read_pct,
                            input bit pop_on_end);
    int unsigned span;
    int unsigned lead;
    int unsigned total;
    int unsigned k;
    logic        lvl;
    settle_line(read_pct);
    span  = int'(sb.bit_period) + 1;
    lead  = int'(sb.first_sample) + 1;
    total = lead + 8 * span + 1;
    for (int unsigned o = 0; o < total; o++) begin
      if (o < lead) begin
        lvl = 1'b0;
      end else begin
        k   = (o - lead) / span;
        lvl = (k < 8) ? data[k] : 1'b1;
      end
      send_tick(lvl, (pop_on_end && o == total - 1) ? 1'b1 : read_roll(read_pct));
    end
  endtask

  // mostly frames with random bytes and gaps, the rest line noise
  task automatic run_mix(input int unsigned budget, input int unsigned read_pct);
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < budget) begin
      if ($urandom_range(99) < 75) begin
        send_frame(8'($urandom), read_pct, 1'b0);
        repeat ($urandom_range(0, 3)) send_tick(1'b1, read_roll(read_pct));
      end else begin
        repeat ($urandom_range(1, 12)) send_tick(1'($urandom), read_roll(read_pct));
      end
    end
  endtask

  // finish any frame, then wait until the block has gone quiet
  task automatic quiesce(input int unsigned read_pct);
    settle_line(read_pct);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // write both timing registers on back-to-back cycles
  task automatic write_timing(input logic [7:0] period, input logic [7:0] first);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BIT_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    sb.set_reg(CFG_BIT_PERIOD, period);
    cfg_idx   <= CFG_FIRST_SAMPLE;
    cfg_wdata <= first;
    @(posedge clk);
    sb.set_reg(CFG_FIRST_SAMPLE, first);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit full_pop_done;
    full_pop_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads of an empty FIFO at the reset timing
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    quiesce(0);

    // fastest timing: all-zero and all-one bytes back to back, then pops
    write_timing(8'd0, 8'd0);
    send_frame(8'h00, 0, 1'b0);
    send_frame(8'hFF, 0, 1'b1);
    repeat (3) send_tick(1'b1, 1'b1);

    // fill the FIFO with no gaps, pop on a full push, then overflow
    calm = 1'b1;
    for (int i = 0; i < 20; i++) begin
      if (i == 4) hold_go = 1'b1;
      send_frame(8'($urandom), 0, !full_pop_done && sb.fill == FIFO_DEPTH);
      if (sb.fill == FIFO_DEPTH && i >= 16) full_pop_done = 1'b1;
    end
    calm = 1'b0;
    quiesce(0);

    write_timing(8'd1, 8'd2);
    run_mix(80, 60);
    quiesce(60);

    write_timing(8'd3, 8'd1);
    run_mix(80, 25);
    quiesce(25);

    // slower timing, a single frame
    write_timing(8'd6, 8'd12);
    send_frame(8'($urandom), 1, 1'b0);
    send_tick(1'b1, 1'b1);
    quiesce(50);

    write_timing(8'd2, 8'd5);
    run_mix(60, 40);
    quiesce(40);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
